FILE: design/hctbp_pkg.sv
// Shared types for the table-driven prefix-code packer.
// Item and result structs, item function codes, front-to-back command format.
// No dependencies.
`default_nettype none

package hctbp_pkg;

  localparam int unsigned ByteBits = 8;

  typedef enum logic [1:0] {
    FUNC_LOAD   = 2'd0,
    FUNC_ENCODE = 2'd1,
    FUNC_FLUSH  = 2'd2
  } func_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [7:0]  symbol;
    logic [31:0] code_word;
    logic [5:0]  code_length;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [3:0] tail_bits;
    logic       is_last;
    logic       missing_code;
  } result_t;

  typedef enum logic [1:0] {
    CMD_ENCODE  = 2'd0,
    CMD_MISSING = 2'd1,
    CMD_FLUSH   = 2'd2
  } cmd_kind_e;

  // code bits are MSB-aligned nowhere: bit 0 is the first bit to pack
  typedef struct packed {
    cmd_kind_e   kind;
    logic [31:0] code;
    logic [5:0]  len;
  } cmd_t;

  typedef enum logic {
    BK_IDLE,
    BK_SHIFT
  } bk_state_e;

endpackage

`default_nettype wire

FILE: design/hctbp_fifo.sv
// Two-entry command queue between the lookup front and the packing back end.
// Generic width; no package dependencies.
`default_nettype none

module hctbp_fifo #(
  parameter int unsigned Width = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             wr_valid_i,
  input  wire logic [Width-1:0] wr_data_i,
  output logic                  full_o,
  input  wire logic             rd_pop_i,
  output logic                  empty_o,
  output logic [Width-1:0]      rd_data_o
);

  logic [Width-1:0] slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == 2'd2);
  assign empty_o   = (count_q == 2'd0);
  assign rd_data_o = slot_q[rd_ptr_q];
  assign do_wr     = wr_valid_i && !full_o;
  assign do_rd     = rd_pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = do_wr ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_rd ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, do_wr} - {1'b0, do_rd};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      slot_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: design/hctbp_front.sv
// Front end: accepts items, owns the code table, classifies encode/flush.
// Depends on hctbp_pkg; emits hctbp_pkg::cmd_t into the command queue.
`default_nettype none

module hctbp_front #(
  parameter int unsigned MaxCodeBits = 32,
  parameter int unsigned SymbolCount = 256
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push,
  output logic                full,
  input  wire hctbp_pkg::item_t item_i,
  output logic                cmd_valid_o,
  output hctbp_pkg::cmd_t     cmd_o,
  input  wire logic           cmd_full_i
);

  localparam int unsigned Lim   = (MaxCodeBits < 32) ? MaxCodeBits : 32;
  localparam int unsigned LenW  = $clog2(Lim + 1);
  localparam int unsigned IdxW  = (SymbolCount > 1) ? $clog2(SymbolCount) : 1;
  localparam int unsigned WordW = Lim + LenW;

  logic [WordW-1:0] mem [SymbolCount];
  logic [WordW-1:0] rd_q;
  logic             vld_q [SymbolCount];

  logic                 s1_valid_q, s1_valid_d;
  hctbp_pkg::cmd_kind_e s1_kind_q;
  logic                 s1_hit_q;

  logic            accept;
  logic            in_range;
  logic [IdxW-1:0] idx;
  logic [5:0]      len_sat;
  logic            is_load, is_encode, is_flush;
  logic            advance;
  logic [LenW-1:0] rd_len;

  assign full     = s1_valid_q && cmd_full_i;
  assign accept   = push && !full;
  assign in_range = ({1'b0, item_i.symbol} < 9'(SymbolCount));
  assign idx      = item_i.symbol[IdxW-1:0];
  assign len_sat  = (item_i.code_length > 6'(Lim)) ? 6'(Lim) : item_i.code_length;

  always_comb begin
    is_load   = 1'b0;
    is_encode = 1'b0;
    is_flush  = 1'b0;
    case (hctbp_pkg::func_e'(item_i.func))
      hctbp_pkg::FUNC_LOAD:   is_load   = 1'b1;
      hctbp_pkg::FUNC_ENCODE: is_encode = 1'b1;
      hctbp_pkg::FUNC_FLUSH:  is_flush  = 1'b1;
      default: ;
    endcase
  end

  assign advance    = s1_valid_q && !cmd_full_i;
  assign s1_valid_d = (accept && (is_encode || is_flush)) ? 1'b1 :
                      (advance ? 1'b0 : s1_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      for (int i = 0; i < SymbolCount; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else begin
      s1_valid_q <= s1_valid_d;
      if (accept && is_load && in_range) begin
        vld_q[idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && is_load && in_range) begin
      mem[idx] <= {len_sat[LenW-1:0], item_i.code_word[Lim-1:0]};
    end
    if (accept && is_encode) begin
      rd_q     <= mem[idx];
      s1_hit_q <= in_range && vld_q[idx];
    end
    if (accept) begin
      s1_kind_q <= is_flush ? hctbp_pkg::CMD_FLUSH : hctbp_pkg::CMD_ENCODE;
    end
  end

  assign rd_len = rd_q[WordW-1:Lim];

  always_comb begin
    cmd_valid_o = s1_valid_q;
    cmd_o.code  = 32'(rd_q[Lim-1:0]);
    cmd_o.len   = 6'(rd_len);
    cmd_o.kind  = s1_kind_q;
    if (s1_kind_q == hctbp_pkg::CMD_ENCODE && (!s1_hit_q || rd_len == '0)) begin
      cmd_o.kind = hctbp_pkg::CMD_MISSING;
    end
  end

endmodule

`default_nettype wire

FILE: design/hctbp_back.sv
// Back end: packs code bits MSB-first, at most one byte per cycle.
// Depends on hctbp_pkg; reads commands from the queue, drives the result register.
`default_nettype none

module hctbp_back (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            cmd_empty_i,
  input  wire hctbp_pkg::cmd_t cmd_i,
  output logic                 cmd_pop_o,
  output logic                 empty,
  input  wire logic            pop,
  output hctbp_pkg::result_t   result_o
);

  hctbp_pkg::bk_state_e state_q, state_d;

  logic [7:0]  pend_q, pend_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] rem_bits_q, rem_bits_d;
  logic [5:0]  rem_len_q, rem_len_d;

  hctbp_pkg::result_t out_q, out_d;
  logic               out_valid_q;
  logic               out_free, emit;

  logic [3:0] room, k, sum, pos, off;
  logic [5:0] rem_after;
  logic [7:0] merged;
  logic       byte_done;

  assign out_free = !out_valid_q || pop;
  assign empty    = !out_valid_q;
  assign result_o = out_q;

  // take as many bits as fit in the pending byte
  always_comb begin
    room      = 4'(hctbp_pkg::ByteBits) - {1'b0, cnt_q};
    k         = (rem_len_q < {2'b0, room}) ? rem_len_q[3:0] : room;
    sum       = {1'b0, cnt_q} + k;
    byte_done = (sum == 4'(hctbp_pkg::ByteBits));
    rem_after = rem_len_q - {2'b0, k};
    merged    = pend_q;
    pos       = '0;
    off       = '0;
    for (int p = 0; p < 8; p++) begin
      pos = 4'(p);
      off = pos - {1'b0, cnt_q};
      if (pos >= {1'b0, cnt_q} && pos < sum) begin
        merged[3'(7 - p)] = rem_bits_q[{2'b0, off[2:0]}];
      end
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      hctbp_pkg::BK_IDLE: begin
        if (!cmd_empty_i && cmd_i.kind == hctbp_pkg::CMD_ENCODE) begin
          state_d = hctbp_pkg::BK_SHIFT;
        end
      end
      hctbp_pkg::BK_SHIFT: begin
        if ((!byte_done || out_free) && rem_after == '0) begin
          state_d = hctbp_pkg::BK_IDLE;
        end
      end
      default: state_d = hctbp_pkg::BK_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_pop_o  = 1'b0;
    emit       = 1'b0;
    out_d      = out_q;
    pend_d     = pend_q;
    cnt_d      = cnt_q;
    rem_bits_d = rem_bits_q;
    rem_len_d  = rem_len_q;
    case (state_q)
      hctbp_pkg::BK_IDLE: begin
        if (!cmd_empty_i) begin
          case (cmd_i.kind)
            hctbp_pkg::CMD_ENCODE: begin
              cmd_pop_o  = 1'b1;
              rem_bits_d = cmd_i.code;
              rem_len_d  = cmd_i.len;
            end
            hctbp_pkg::CMD_MISSING: begin
              if (out_free) begin
                cmd_pop_o = 1'b1;
                emit      = 1'b1;
                out_d     = '{out_byte: 8'd0, tail_bits: 4'd8, is_last: 1'b1,
                              missing_code: 1'b1};
              end
            end
            hctbp_pkg::CMD_FLUSH: begin
              if (out_free) begin
                cmd_pop_o = 1'b1;
                emit      = 1'b1;
                out_d     = '{out_byte: pend_q,
                              tail_bits: (cnt_q == '0) ? 4'd8 : {1'b0, cnt_q},
                              is_last: 1'b1, missing_code: 1'b0};
                pend_d    = '0;
                cnt_d     = '0;
              end
            end
            default: ;
          endcase
        end
      end
      hctbp_pkg::BK_SHIFT: begin
        if (!byte_done || out_free) begin
          rem_bits_d = rem_bits_q >> k;
          rem_len_d  = rem_after;
          if (byte_done) begin
            // last result of the item when no further byte can complete
            emit   = 1'b1;
            out_d  = '{out_byte: merged, tail_bits: 4'd8,
                       is_last: (rem_after < 6'(hctbp_pkg::ByteBits)),
                       missing_code: 1'b0};
            pend_d = '0;
            cnt_d  = '0;
          end else begin
            pend_d = merged;
            cnt_d  = sum[2:0];
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= hctbp_pkg::BK_IDLE;
      pend_q      <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      rem_len_q   <= '0;
    end else begin
      state_q   <= state_d;
      pend_q    <= pend_d;
      cnt_q     <= cnt_d;
      rem_len_q <= rem_len_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rem_bits_q <= rem_bits_d;
    out_q      <= out_d;
  end

  a_shift_has_bits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == hctbp_pkg::BK_SHIFT |-> rem_len_q != '0)
    else $error("shift state with no bits left");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_pop_o |-> state_q == hctbp_pkg::BK_IDLE)
    else $error("command taken while packing");

  a_missing_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.missing_code |->
      out_q.is_last && out_q.tail_bits == 4'd8 && out_q.out_byte == 8'd0)
    else $error("malformed missing-code result");

endmodule

`default_nettype wire

FILE: design/huffman_code_table_bit_packer.sv
// Table-driven prefix-code encoder, MSB-first byte packing.
// Flush or missing-code results pass front stage, command queue and result register;
// encode bytes also pass the back end's shift state. Front takes one transaction a cycle
// unless the queue backs up; loads end there. A held result stalls the back end.
// Reset clears the table's valid flops at once and empties pending bits; no sweep.
// Depends on hctbp_pkg, hctbp_front, hctbp_fifo, hctbp_back.
`default_nettype none

module huffman_code_table_bit_packer #(
  parameter int unsigned MAX_CODE_BITS = 32,
  parameter int unsigned SYMBOL_COUNT  = 256
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire hctbp_pkg::item_t   item_i,
  output logic                    empty,
  input  wire logic               pop,
  output hctbp_pkg::result_t      result_o
);

  localparam int unsigned CmdW = $bits(hctbp_pkg::cmd_t);

  logic            cmd_valid, cmd_full, cmd_empty, cmd_pop;
  hctbp_pkg::cmd_t cmd_in, cmd_out;
  logic [CmdW-1:0] cmd_out_bits;

  hctbp_front #(
    .MaxCodeBits (MAX_CODE_BITS),
    .SymbolCount (SYMBOL_COUNT)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .item_i      (item_i),
    .cmd_valid_o (cmd_valid),
    .cmd_o       (cmd_in),
    .cmd_full_i  (cmd_full)
  );

  hctbp_fifo #(
    .Width (CmdW)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (cmd_valid),
    .wr_data_i  (cmd_in),
    .full_o     (cmd_full),
    .rd_pop_i   (cmd_pop),
    .empty_o    (cmd_empty),
    .rd_data_o  (cmd_out_bits)
  );

  assign cmd_out = hctbp_pkg::cmd_t'(cmd_out_bits);

  hctbp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_empty_i (cmd_empty),
    .cmd_i       (cmd_out),
    .cmd_pop_o   (cmd_pop),
    .empty       (empty),
    .pop         (pop),
    .result_o    (result_o)
  );

endmodule

`default_nettype wire

FILE: tb/testbench.sv
// Self-checking testbench for huffman_code_table_bit_packer: directed and random
// load/encode/flush traffic, queue-style handshakes on both sides, in-line packing model.
// Depends on hctbp_pkg and the packer RTL.
`timescale 1ns / 100ps

module testbench;

  localparam logic [1:0] FuncUnused = 2'd3;
  localparam int unsigned StallLimit = 3000;
  localparam int unsigned PhaseItems = 77;
  localparam int unsigned PoolSize = 16;
  localparam int unsigned MaxReported = 10;

  typedef struct {
    hctbp_pkg::item_t item;
    bit               drain;
    int unsigned      phase;
  } feed_entry_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               push = 1'b0;
  logic               full;
  hctbp_pkg::item_t   item_i = '0;
  logic               empty;
  logic               pop = 1'b0;
  hctbp_pkg::result_t result_o;

  huffman_code_table_bit_packer uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .item_i   (item_i),
    .empty    (empty),
    .pop      (pop),
    .result_o (result_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // packing model state
  logic [31:0] code_bits [256];
  logic [5:0]  code_len [256];
  logic [7:0]  acc_byte = '0;
  logic [3:0]  acc_count = '0;

  feed_entry_t        item_feed_q[$];
  hctbp_pkg::result_t owed_results_q[$];
  logic [7:0]         sym_pool [PoolSize];

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned results_owed = 0;
  int unsigned fail_count = 0;
  int unsigned stall_cycles = 0;
  bit          drain_wait = 1'b0;
  logic        push_next;
  feed_entry_t feed_entry;

  function automatic int unsigned sender_idle(input int unsigned phase);
    return (phase == 0) ? 12 : (phase == 1) ? 81 : 0;
  endfunction

  function automatic int unsigned receiver_idle(input int unsigned phase);
    return (phase == 0) ? 81 : (phase == 1) ? 12 : 0;
  endfunction

  function automatic void queue_item(input logic [1:0] func, input logic [7:0] sym,
                                     input logic [31:0] word, input logic [5:0] len,
                                     input bit drain, input int unsigned phase);
    feed_entry_t e;
    e.item.func        = func;
    e.item.symbol      = sym;
    e.item.code_word   = word;
    e.item.code_length = len;
    e.drain            = drain;
    e.phase            = phase;
    item_feed_q.push_back(e);
  endfunction

  function automatic logic [5:0] random_length();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 70) return 6'($urandom_range(12, 1));
    if (roll < 90) return 6'($urandom_range(32, 13));
    if (roll < 95) return 6'd0;
    return 6'($urandom_range(63, 33));
  endfunction

  function automatic void queue_random(input bit drain, input int unsigned phase);
    int unsigned roll;
    logic [7:0]  sym;
    roll = $urandom_range(99);
    sym  = ($urandom_range(99) < 85) ? sym_pool[$urandom_range(PoolSize - 1)]
                                     : 8'($urandom_range(255));
    if (roll < 10) begin
      queue_item(hctbp_pkg::FUNC_LOAD, sym, $urandom(), random_length(), drain, phase);
    end else if (roll < 85) begin
      queue_item(hctbp_pkg::FUNC_ENCODE, sym, $urandom(), 6'($urandom_range(63)), drain,
                 phase);
    end else if (roll < 97) begin
      queue_item(hctbp_pkg::FUNC_FLUSH, sym, $urandom(), 6'($urandom_range(63)), drain,
                 phase);
    end else begin
      queue_item(FuncUnused, sym, $urandom(), 6'($urandom_range(63)), drain, phase);
    end
  endfunction

  function automatic void owe(input logic [7:0] b, input logic [3:0] tail,
                              input logic last, input logic missing);
    hctbp_pkg::result_t r;
    r.out_byte     = b;
    r.tail_bits    = tail;
    r.is_last      = last;
    r.missing_code = missing;
    owed_results_q.push_back(r);
  endfunction

  // append the expected output of one accepted transaction
  function automatic void pack_item(input hctbp_pkg::item_t it);
    int unsigned produced;
    logic [7:0]  sym;
    sym      = it.symbol;
    produced = 0;
    case (it.func)
      hctbp_pkg::FUNC_LOAD: begin
        code_bits[sym] = it.code_word;
        code_len[sym]  = (it.code_length > 6'd32) ? 6'd32 : it.code_length;
      end
      hctbp_pkg::FUNC_ENCODE: begin
        if (code_len[sym] == 6'd0) begin
          owe(8'h00, 4'd8, 1'b1, 1'b1);
        end else begin
          for (int i = 0; i < code_len[sym]; i++) begin
            acc_byte[3'(7 - acc_count)] = code_bits[sym][i];
            acc_count = acc_count + 4'd1;
            if (acc_count == 4'd8) begin
              owe(acc_byte, 4'd8, 1'b0, 1'b0);
              produced++;
              acc_byte  = '0;
              acc_count = '0;
            end
          end
          if (produced > 0) owed_results_q[$].is_last = 1'b1;
        end
      end
      hctbp_pkg::FUNC_FLUSH: begin
        if (acc_count != 4'd0) begin
          owe(acc_byte, acc_count, 1'b1, 1'b0);
          acc_byte  = '0;
          acc_count = '0;
        end else begin
          owe(8'h00, 4'd8, 1'b1, 1'b0);
        end
      end
      default: ;
    endcase
  endfunction

  function automatic void check_result(input hctbp_pkg::result_t got);
    hctbp_pkg::result_t want;
    if (owed_results_q.size() == 0) begin
      fail_count++;
      if (fail_count <= MaxReported)
        $display("%0t: unexpected result byte=%h tail=%0d last=%b missing=%b", $time,
                 got.out_byte, got.tail_bits, got.is_last, got.missing_code);
      return;
    end
    want = owed_results_q.pop_front();
    if (got.out_byte !== want.out_byte || got.tail_bits !== want.tail_bits ||
        got.is_last !== want.is_last || got.missing_code !== want.missing_code) begin
      fail_count++;
      if (fail_count <= MaxReported)
        $display("%0t: exp b=%h t=%0d l=%b m=%b, got b=%h t=%0d l=%b m=%b",
                 $time, want.out_byte, want.tail_bits, want.is_last, want.missing_code,
                 got.out_byte, got.tail_bits, got.is_last, got.missing_code);
    end
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!push || !full) begin
        push_next = 1'b0;
        if (item_feed_q.size() != 0) begin
          // hold push low until results_owed, which then covers everything sent, falls to zero
          if (item_feed_q[0].drain) begin
            if (drain_wait && results_owed == 0) begin
              item_feed_q[0].drain = 1'b0;
              drain_wait = 1'b0;
            end else begin
              drain_wait = 1'b1;
            end
          end
          if (!item_feed_q[0].drain && $urandom_range(99) >= send_idle_pct) begin
            feed_entry    = item_feed_q.pop_front();
            item_i        <= feed_entry.item;
            send_idle_pct = sender_idle(feed_entry.phase);
            recv_idle_pct <= receiver_idle(feed_entry.phase);
            push_next     = 1'b1;
          end
        end
        push <= push_next;
      end
    end
  end

  // monitor, predictor and watchdog
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) check_result(result_o);
      if (push && !full) pack_item(item_i);
      results_owed <= owed_results_q.size();
      pop <= ($urandom_range(99) >= recv_idle_pct);
      if ((pop && !empty) || (push && !full)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= StallLimit) begin
          $display("%0t: no transaction for %0d cycles, %0d results owed", $time,
                   stall_cycles, owed_results_q.size());
          $display("SCOREBOARD MISMATCH");
          $finish;
        end
      end
    end
  end

  initial begin
    for (int i = 0; i < 256; i++) begin
      code_len[i]  = '0;
      code_bits[i] = '0;
    end
    foreach (sym_pool[k]) sym_pool[k] = 8'($urandom_range(255));
    send_idle_pct = sender_idle(0);
    recv_idle_pct = receiver_idle(0);

    // directed: empty flush, missing codes, saturation, clears, byte packing
    queue_item(hctbp_pkg::FUNC_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, 0);
    queue_item(hctbp_pkg::FUNC_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b0, 0);
    queue_item(FuncUnused,             8'hff, 32'hffff_ffff, 6'd63, 1'b0, 0);
    queue_item(hctbp_pkg::FUNC_LOAD,   8'h00, 32'h0000_0001, 6'd1,  1'b0, 0);
    queue_item(hctbp_pkg::FUNC_LOAD,   8'hff, 32'hffff_ffff, 6'd32, 1'b0, 0);
    queue_item(hctbp_pkg::FUNC_LOAD,   8'h80, 32'h0f0f_3c5a, 6'd63, 1'b0, 0);
    queue_item(hctbp_pkg::FUNC_LOAD,   8'h01, 32'h0000_0000, 6'd0,  1'b0, 0);
    queue_item(hctbp_pkg::FUNC_ENCODE, 8'h01, 32'hffff_ffff, 6'd63, 1'b0, 0);
    queue_item(hctbp_pkg::FUNC_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b0, 0);
    queue_item(hctbp_pkg::FUNC_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, 0);
    queue_item(hctbp_pkg::FUNC_ENCODE, 8'hff, 32'h0000_0000, 6'd0,  1'b0, 0);
    queue_item(hctbp_pkg::FUNC_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b0, 0);
    queue_item(hctbp_pkg::FUNC_ENCODE, 8'hff, 32'h0000_0000, 6'd0,  1'b0, 0);
    queue_item(hctbp_pkg::FUNC_ENCODE, 8'h80, 32'h0000_0000, 6'd0,  1'b0, 0);
    queue_item(hctbp_pkg::FUNC_LOAD,   8'h02, 32'h0000_0055, 6'd7,  1'b0, 0);
    queue_item(hctbp_pkg::FUNC_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  1'b0, 0);
    queue_item(hctbp_pkg::FUNC_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  1'b0, 0);
    queue_item(hctbp_pkg::FUNC_ENCODE, 8'h03, 32'h0000_0000, 6'd0,  1'b0, 0);
    queue_item(hctbp_pkg::FUNC_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, 0);
    queue_item(hctbp_pkg::FUNC_LOAD,   8'hff, 32'h0000_0000, 6'd0,  1'b0, 0);
    queue_item(hctbp_pkg::FUNC_ENCODE, 8'hff, 32'h0000_0000, 6'd0,  1'b0, 0);
    queue_item(hctbp_pkg::FUNC_LOAD,   8'h00, 32'h0000_0000, 6'd8,  1'b0, 0);
    queue_item(hctbp_pkg::FUNC_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b0, 0);
    queue_item(hctbp_pkg::FUNC_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, 0);

    // random: give the symbol pool codes, then mostly encodes of pool symbols
    foreach (sym_pool[k])
      queue_item(hctbp_pkg::FUNC_LOAD, sym_pool[k], $urandom(), random_length(), 1'b0, 0);
    for (int p = 0; p < 3; p++)
      for (int n = 0; n < PhaseItems; n++)
        queue_random(p != 0 && n == 0, p);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i); while (item_feed_q.size() != 0 || push);
    while (owed_results_q.size() != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);

    if (fail_count == 0 && owed_results_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
